// File: rtl/core/rlm_pkg.sv
// ----------------------------------------------------------------------------
// rlm_pkg: shared types and constants for the RMS level meter
// Request codes, fixed field widths and the control word of the step unit.
// ----------------------------------------------------------------------------
package rlm_pkg;

    localparam int REQ_W      = 2;
    localparam int SAMPLE_W   = 16;
    localparam int LEVEL_W    = 16;
    localparam int SUM_W      = 64;
    localparam int COUNT_W    = 16;
    localparam int SQUARE_W   = 31;
    localparam int ROOT_W     = 15;
    localparam int ROOT_REM_W = 18;
    localparam int DIV_STEPS  = 64;
    localparam int ROOT_STEPS = 15;
    localparam int MEAN_TOP   = 30;
    localparam int CNT_W      = 6;

    typedef logic [REQ_W-1:0] req_t;

    localparam req_t REQ_SAMPLE     = 2'd0;
    localparam req_t REQ_SAMPLE_END = 2'd1;
    localparam req_t REQ_MISSING    = 2'd2;
    localparam req_t REQ_READ       = 2'd3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [LEVEL_W-1:0] RMS_SAT   = 16'h8000;

    // Control word of the shared compare-subtract step
    typedef struct packed {
        logic       sqrt_mode;
        logic [1:0] shin;
    } step_ctl_t;

endpackage

// File: rtl/core/rms_level_meter_unit.sv
// ----------------------------------------------------------------------------
// rms_level_meter_unit: RMS level meter for Q1.15 audio
// Sums squared samples, counts blocks and on a read returns the root of the
// mean square, then clears the sum and the count.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake           | Payload
//  --------+---------------------+----------------------------------
//  in      | in_valid / in_stall | req_type[1:0], sample[15:0] signed
//  out     | out_valid/out_stall | rms_level[15:0], valid_res
//
//  Sample, block-end and missing-block items may follow back to back; the square is
//  added in the cycle after acceptance. A read runs a 64-step division, one range check
//  and a 15-step root on one shared compare-subtract unit; its result shows after the
//  last root step (after the range check when the level saturates, straight from the
//  read with no counted block), in_stall high meanwhile.
//  A waiting result holds off only a further read; reset clears sum, count, sequencer.
//
module rms_level_meter_unit #(
    parameter int BLOCK_SAMPLES = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  rlm_pkg::req_t                 req_type,
    input  logic signed [rlm_pkg::SAMPLE_W-1:0] sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rlm_pkg::LEVEL_W-1:0]   rms_level,
    output logic                          valid_res
);
    import rlm_pkg::*;

    // Divisor is blocks times BLOCK_SAMPLES
    localparam int DIV_W = COUNT_W + $clog2(BLOCK_SAMPLES);
    localparam int SUB_W = (DIV_W + 1 > ROOT_REM_W) ? DIV_W + 1 : ROOT_REM_W;
    localparam logic [DIV_W-1:0] BLOCK_LEN = DIV_W'(BLOCK_SAMPLES);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_ROOT = 3'd3;

    logic [2:0]         state_reg,   state_next;
    logic [CNT_W-1:0]   cnt_reg,     cnt_next;
    logic [SUM_W-1:0]   quot_reg,    quot_next;
    logic [SUB_W-1:0]   rem_reg,     rem_next;
    logic [DIV_W-1:0]   divisor_reg, divisor_next;
    logic [ROOT_W-1:0]  root_reg,    root_next;
    logic [LEVEL_W-1:0] rms_reg,     rms_next;
    logic               vres_reg,    vres_next;
    logic               out_valid_reg, out_valid_next;

    logic               in_take;
    logic [SUM_W-1:0]   sum_now;
    logic [COUNT_W-1:0] block_count;
    step_ctl_t          step_ctl;
    logic [SUB_W-1:0]   step_rem;
    logic               step_bit;

    // Hold every item while the sequencer runs; hold a read while a result waits
    assign in_take   = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && (req_type == REQ_READ));
    assign out_valid = out_valid_reg;
    assign rms_level = rms_reg;
    assign valid_res = vres_reg;

    rlm_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (in_take),
        .req_type    (req_type),
        .sample      (sample),
        .sum_now     (sum_now),
        .block_count (block_count)
    );

    // Division feeds the top quotient bit; the root takes the next two bits
    // of the mean, which the range check left below bit 30
    assign step_ctl.sqrt_mode = (state_reg == ST_ROOT);
    assign step_ctl.shin      = (state_reg == ST_ROOT) ? quot_reg[MEAN_TOP-1:MEAN_TOP-2]
                                                       : {quot_reg[SUM_W-1], 1'b0};

    rlm_step_unit #(
        .W (SUB_W)
    ) u_step (
        .ctl     (step_ctl),
        .rem     (rem_reg),
        .divisor (SUB_W'(divisor_reg)),
        .root    (root_reg),
        .rem_new (step_rem),
        .bit_new (step_bit)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        divisor_next   = divisor_reg;
        root_next      = root_reg;
        rms_next       = rms_reg;
        vres_next      = vres_reg;
        // Drop the result once taken
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                // Latch the sum with any pending square and the divisor
                if (in_take && (req_type == REQ_READ))
                begin
                    quot_next    = sum_now;
                    divisor_next = DIV_W'(block_count) * BLOCK_LEN;
                    rem_next     = '0;
                    cnt_next     = '0;
                    if (block_count == '0)
                    begin
                        rms_next       = '0;
                        vres_next      = 1'b0;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next  = step_rem;
                quot_next = {quot_reg[SUM_W-2:0], step_bit};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                // A mean of 2^30 or more has a root of at least 32768
                if (|quot_reg[SUM_W-1:MEAN_TOP])
                begin
                    rms_next       = RMS_SAT;
                    vres_next      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                rem_next  = step_rem;
                root_next = {root_reg[ROOT_W-2:0], step_bit};
                quot_next = {quot_reg[SUM_W-3:0], 2'b00};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ROOT_STEPS - 1))
                begin
                    rms_next       = {1'b0, root_reg[ROOT_W-2:0], step_bit};
                    vres_next      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        root_reg    <= root_next;
        rms_reg     <= rms_next;
        vres_reg    <= vres_next;
    end

`ifndef SYNTH
    // A waiting result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(rms_level) && $stable(valid_res)))
        else $error("waiting result changed");

    // A read clears the block count in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && (req_type == REQ_READ)) |=> (block_count == '0))
        else $error("block count not cleared by read");

    // The root never runs past its last step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT) |-> (cnt_reg < CNT_W'(ROOT_STEPS)))
        else $error("root step counter overran");

    // A taken result is gone in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> !out_valid)
        else $error("result repeated after being taken");
`endif

endmodule

// File: rtl/core/rlm_step_unit.sv
// ----------------------------------------------------------------------------
// rlm_step_unit: shared shift, compare and subtract step
// One step of restoring division or of the digit-by-digit square root.
// ----------------------------------------------------------------------------
module rlm_step_unit #(
    parameter int W = 27
) (
    input  rlm_pkg::step_ctl_t         ctl,
    input  logic [W-1:0]               rem,
    input  logic [W-1:0]               divisor,
    input  logic [rlm_pkg::ROOT_W-1:0] root,
    output logic [W-1:0]               rem_new,
    output logic                       bit_new
);
    import rlm_pkg::*;

    logic [W-1:0] cand;
    logic [W-1:0] sub;
    logic         ge;

    // Division shifts in one dividend bit, the root two radicand bits
    assign cand = ctl.sqrt_mode ? {rem[W-3:0], ctl.shin} : {rem[W-2:0], ctl.shin[1]};
    assign sub  = ctl.sqrt_mode ? W'({root, 2'b01}) : divisor;
    assign ge   = (cand >= sub);

    assign rem_new = ge ? (cand - sub) : cand;
    assign bit_new = ge;

endmodule

// File: rtl/core/rlm_accum.sv
// ----------------------------------------------------------------------------
// rlm_accum: square and accumulate stage
// Squares samples, keeps the saturating sum of squares and the block count.
// ----------------------------------------------------------------------------
module rlm_accum (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        take,
    input  rlm_pkg::req_t               req_type,
    input  logic signed [rlm_pkg::SAMPLE_W-1:0] sample,
    output logic [rlm_pkg::SUM_W-1:0]   sum_now,
    output logic [rlm_pkg::COUNT_W-1:0] block_count
);
    import rlm_pkg::*;

    logic [SAMPLE_W:0]      mag;
    logic [2*SAMPLE_W+1:0]  prod;
    logic [SQUARE_W-1:0]    sq_reg;
    logic                   sq_pend_reg;
    logic                   sq_pend_next;
    logic [SUM_W-1:0]       sum_reg;
    logic [SUM_W-1:0]       sum_next;
    logic [SUM_W:0]         sum_wide;
    logic [COUNT_W-1:0]     count_reg;
    logic [COUNT_W-1:0]     count_next;
    logic                   is_read;
    logic                   is_square;
    logic                   is_block;

    assign is_read   = take && (req_type == REQ_READ);
    assign is_square = take && ((req_type == REQ_SAMPLE) || (req_type == REQ_SAMPLE_END));
    assign is_block  = take && ((req_type == REQ_SAMPLE_END) || (req_type == REQ_MISSING));

    // Magnitude reaches 32768, so the square stays within 31 bits
    assign mag  = sample[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {sample[SAMPLE_W-1], sample})
                                     : {1'b0, sample};
    assign prod = mag * mag;

    // Fold in the square left from the previous cycle, saturating at all ones
    assign sum_wide = {1'b0, sum_reg} + {{(SUM_W-SQUARE_W+1){1'b0}}, sq_reg};
    assign sum_now  = !sq_pend_reg ? sum_reg : (sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0]);

    assign sum_next     = is_read ? '0 : sum_now;
    assign sq_pend_next = is_square;
    assign block_count  = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (is_read)
        begin
            count_next = '0;
        end
        else if (is_block && (count_reg != COUNT_MAX))
        begin
            count_next = count_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg     <= '0;
            count_reg   <= '0;
            sq_pend_reg <= 1'b0;
        end
        else
        begin
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            sq_pend_reg <= sq_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_square)
        begin
            sq_reg <= prod[SQUARE_W-1:0];
        end
    end

endmodule
